// File: hw/rtl/xbr_pkg.sv
`timescale 1ns / 1ps

package xbr_pkg;

  localparam int unsigned WordW      = 64;
  localparam int unsigned LimitW     = 32;
  localparam int unsigned IndexW     = 32;
  localparam int unsigned NumWords   = 4;

  localparam logic [WordW-1:0] SeedReset = 64'd123;

  // state advance
  localparam int unsigned ShiftAdv   = 17;
  localparam int unsigned RotAdv     = 45;
  // scrambler: rotl(s1 * 5, 7) * 9
  localparam int unsigned MulAShift  = 2;
  localparam int unsigned RotOut     = 7;
  localparam int unsigned MulBShift  = 3;

  // fixed-point fraction taken from the raw word, split for two narrow multiplies
  localparam int unsigned FracShift  = 12;
  localparam int unsigned FracW      = WordW - FracShift;
  localparam int unsigned FracLoW    = 32;
  localparam int unsigned FracHiW    = FracW - FracLoW;

  typedef struct packed {
    logic [WordW-1:0]  word1;
    logic [LimitW-1:0] limit;
  } xbr_entry_t;

  function automatic logic [WordW-1:0] rotl64(input logic [WordW-1:0] x,
                                              input int unsigned k);
    return (x << k) | (x >> (WordW - k));
  endfunction

endpackage

// File: hw/rtl/xbr_front.sv
`timescale 1ns / 1ps

module xbr_front import xbr_pkg::*; #(
  parameter int unsigned LIMIT_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WordW-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic [LimitW-1:0] range_limit_i,
  output logic              in_stall_o,
  input  logic              full_i,
  output logic              push_o,
  output xbr_entry_t        push_data_o
);

  localparam logic [LimitW-1:0] LimMask =
    (LIMIT_BITS >= LimitW) ? {LimitW{1'b1}} : LimitW'((64'd1 << LIMIT_BITS) - 64'd1);

  logic [WordW-1:0] words_q [NumWords];
  logic [WordW-1:0] words_d [NumWords];
  logic [WordW-1:0] n2, n3, t;
  logic             accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    t  = words_q[1] << ShiftAdv;
    n2 = words_q[2] ^ words_q[0];
    n3 = words_q[3] ^ words_q[1];
    words_d[1] = words_q[1] ^ n2;
    words_d[0] = words_q[0] ^ n3;
    words_d[2] = n2 ^ t;
    words_d[3] = rotl64(n3, RotAdv);
  end

  assign push_o            = accept;
  assign push_data_o.word1 = words_d[1];
  assign push_data_o.limit = range_limit_i & LimMask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumWords; i++) begin
        words_q[i] <= SeedReset + WordW'(i);
      end
    end else if (cfg_we_i) begin
      for (int i = 0; i < NumWords; i++) begin
        words_q[i] <= cfg_wdata_i + WordW'(i);
      end
    end else if (accept) begin
      words_q <= words_d;
    end
  end

endmodule

// File: hw/rtl/xbr_queue.sv
`timescale 1ns / 1ps

module xbr_queue import xbr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  xbr_entry_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output xbr_entry_t pop_data_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  xbr_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// File: hw/rtl/xbr_back.sv
`timescale 1ns / 1ps

module xbr_back import xbr_pkg::*; #(
  parameter int unsigned LIMIT_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  xbr_entry_t        q_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IndexW-1:0] index_o,
  output logic [WordW-1:0]  raw_value_o
);

  localparam int unsigned LimW = (LIMIT_BITS < LimitW) ? LIMIT_BITS : LimitW;
  localparam int unsigned PHiW = FracHiW + LimW;
  localparam int unsigned PLoW = FracLoW + LimW;
  localparam int unsigned SumW = PHiW + 1;

  logic adv;

  logic             v1_q, v2_q, v3_q, vo_q;
  logic [WordW-1:0] x1_q, raw2_q, raw3_q, raw_q;
  logic [LimW-1:0]  lim1_q, lim2_q;
  logic [PHiW-1:0]  phi3_q, phi_d;
  logic [PLoW-1:0]  plo3_q, plo_d;
  logic [IndexW-1:0] index_q;

  logic [WordW-1:0] s1, x1_d, y2, raw2_d;
  logic [FracW-1:0] frac;
  logic [SumW-1:0]  sum;

  // whole pipe moves together once the output register frees up
  assign adv   = !vo_q || !out_stall_i;
  assign pop_o = q_valid_i && adv;

  assign s1     = q_data_i.word1;
  assign x1_d   = s1 + (s1 << MulAShift);
  assign y2     = rotl64(x1_q, RotOut);
  assign raw2_d = y2 + (y2 << MulBShift);

  assign frac  = raw2_q[WordW-1:FracShift];
  assign phi_d = PHiW'(frac[FracW-1:FracLoW]) * PHiW'(lim2_q);
  assign plo_d = PLoW'(frac[FracLoW-1:0]) * PLoW'(lim2_q);

  // floor(frac*lim / 2^52) = (p_hi + (p_lo >> 32)) >> 20
  assign sum = SumW'(phi3_q) + SumW'(plo3_q[PLoW-1:FracLoW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= q_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_q    <= x1_d;
      lim1_q  <= q_data_i.limit[LimW-1:0];
      raw2_q  <= raw2_d;
      lim2_q  <= lim1_q;
      phi3_q  <= phi_d;
      plo3_q  <= plo_d;
      raw3_q  <= raw2_q;
      index_q <= IndexW'(sum[FracHiW +: LimW]);
      raw_q   <= raw3_q;
    end
  end

  assign out_valid_o = vo_q;
  assign index_o     = index_q;
  assign raw_value_o = raw_q;

endmodule

// File: hw/rtl/xoshiro256ss_bounded_random_core.sv
`timescale 1ns / 1ps
// Bounded random index generator, xoshiro256** state with a fixed-point bound.
// Request channel: in_valid_i / in_stall_o carry range_limit_i, the exclusive
//   upper bound (only its low LIMIT_BITS bits count; a zero bound gives index 0).
// Response channel: out_valid_o / out_stall_i carry index_o and raw_value_o.
//   A transfer happens on a clock edge with valid high and stall low.
// Seed: cfg_we_i loads state word i with cfg_wdata_i + i; write only while idle.
// Path: state advance at accept, then queue, scramble add, scramble add, multiply,
//   index add/output; the back-end stages hold while a response is stalled.
// Throughput: one request per cycle while the response side keeps up; the
//   state advance is a combinational xor/shift/rotate update of registered state.
// The front end takes requests until the 4-entry queue is full; the back-end
//   pipeline freezes as a whole while a response sits stalled in its output
//   register, so up to 8 requests can be in flight before in_stall_o rises.
// Reset: state words load 123 + i, queue and pipeline empty; no clearing pass.

module xoshiro256ss_bounded_random_core import xbr_pkg::*; #(
  parameter int unsigned LIMIT_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WordW-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [LimitW-1:0] range_limit_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IndexW-1:0] index_o,
  output logic [WordW-1:0]  raw_value_o
);

  logic       push, full, pop, q_valid;
  xbr_entry_t push_data, q_data;

  xbr_front #(.LIMIT_BITS(LIMIT_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .range_limit_i(range_limit_i),
    .in_stall_o   (in_stall_o),
    .full_i       (full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  xbr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_data_o (q_data)
  );

  xbr_back #(.LIMIT_BITS(LIMIT_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .index_o    (index_o),
    .raw_value_o(raw_value_o)
  );

endmodule

// File: hw/rtl/xbr_checker.sv
`timescale 1ns / 1ps

module xbr_checker import xbr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [IndexW-1:0] index_o,
  input logic [WordW-1:0]  raw_value_o
);

  // response held while stalled
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("response dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(index_o) && $stable(raw_value_o))
    else $error("response payload changed while stalled");

  // nothing comes out while in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("response valid during reset");

  // index stays strictly below the largest 32-bit bound
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> index_o != {IndexW{1'b1}})
    else $error("index out of range");

endmodule

bind xoshiro256ss_bounded_random_core xbr_checker u_chk (.*);
